FILE: rtl/stfcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stfcs_pkg
// Shared constants, request codes and controller/datapath types for the
// sorted table floor/ceiling search block.
// ----------------------------------------------------------------------------
package stfcs_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 64;

  // fixed field widths
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 10;
  localparam int FKEY_W  = 64;
  localparam int CFG_W   = 11;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 2;

  // derived widths
  localparam int POS_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = POS_W + 1;
  localparam int SIDX_W  = POS_W + 2;

  typedef logic signed [SIDX_W-1:0] sidx_t;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FLOOR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CEIL  = 2'd2;

  // register addresses
  localparam logic [APB_AW-1:0] ADDR_ENTRIES = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_PROBE,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic wr_entry;   // store write transaction into the table
    logic load;       // capture search transaction, init bounds
    logic issue;      // first table read from current bounds
    logic step;       // compare probe, narrow bounds, next read
    logic out_load;   // load result into output register
  } ctl_cmd_t;

  typedef struct packed {
    logic range_empty;
    logic step_done;
  } dp_status_t;

endpackage : stfcs_pkg
`default_nettype wire

FILE: rtl/stfcs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stfcs_req_if / stfcs_rsp_if
// Valid/ready channels for search requests and search results.
// ----------------------------------------------------------------------------
interface stfcs_req_if;
  logic                            valid;
  logic                            ready;
  logic [stfcs_pkg::REQ_W-1:0]     req_type;
  logic [stfcs_pkg::IDX_W-1:0]     entry_index;
  logic [stfcs_pkg::FKEY_W-1:0]    key_value;

  modport source (output valid, output req_type, output entry_index,
                  output key_value, input ready);
  modport sink   (input valid, input req_type, input entry_index,
                  input key_value, output ready);
endinterface : stfcs_req_if

interface stfcs_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [stfcs_pkg::IDX_W-1:0]     position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface : stfcs_rsp_if
`default_nettype wire

FILE: rtl/stfcs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stfcs_ctrl
// Sequencer for table writes and binary searches; owns the handshakes.
// ----------------------------------------------------------------------------
module stfcs_ctrl (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [stfcs_pkg::REQ_W-1:0]    in_req_type,
  output logic                          out_valid,
  input  wire                           out_ready,
  input  wire stfcs_pkg::dp_status_t    status,
  output stfcs_pkg::ctl_cmd_t           cmd
);
  import stfcs_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_req_type)
            REQ_WRITE: cmd.wr_entry = 1'b1;
            REQ_FLOOR, REQ_CEIL: begin
              cmd.load  = 1'b1;
              state_nxt = ST_START;
            end
            default: ;  // unused code: dropped
          endcase
        end
      end
      ST_START: begin
        if (status.range_empty) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.issue = 1'b1;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd.step = 1'b1;
        if (status.step_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule : stfcs_ctrl
`default_nettype wire

FILE: rtl/stfcs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stfcs_dp
// Key table memory, search bounds, probe compare and result register.
// ----------------------------------------------------------------------------
module stfcs_dp (
  input  wire                           clk,
  input  wire stfcs_pkg::ctl_cmd_t      cmd,
  input  wire [stfcs_pkg::REQ_W-1:0]    in_req_type,
  input  wire [stfcs_pkg::IDX_W-1:0]    in_entry_index,
  input  wire [stfcs_pkg::FKEY_W-1:0]   in_key_value,
  input  wire [stfcs_pkg::CFG_W-1:0]    entries_in_use,
  output stfcs_pkg::dp_status_t         status,
  output logic                          out_found,
  output logic [stfcs_pkg::IDX_W-1:0]   out_position
);
  import stfcs_pkg::*;

  logic [KEY_WIDTH-1:0] key_table [TABLE_DEPTH];

  logic [KEY_WIDTH-1:0] rd_data_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic                 ceil_r;
  logic                 hit_r;
  sidx_t                lo_r, hi_r;
  sidx_t                n_r;
  logic [POS_W-1:0]     mid_r;
  logic                 out_found_r;
  logic [IDX_W-1:0]     out_pos_r;

  logic [CNT_W-1:0]     n_clamp;
  sidx_t                sum_reg, sum_new;
  logic [POS_W-1:0]     mid_reg, mid_new;
  sidx_t                lo_new, hi_new;
  logic                 p_lt, p_gt, p_eq;
  logic                 rd_en;
  logic [POS_W-1:0]     rd_addr;
  logic                 wr_ok;
  logic                 res_found;
  logic [POS_W-1:0]     res_pos;

  assign n_clamp = (32'(entries_in_use) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(entries_in_use);

  // bounds are non-negative whenever a midpoint is taken
  assign sum_reg = lo_r + hi_r;
  assign mid_reg = POS_W'(sum_reg >>> 1);

  assign p_lt = rd_data_r < key_r;
  assign p_gt = rd_data_r > key_r;
  assign p_eq = !p_lt && !p_gt;

  always_comb begin
    lo_new = lo_r;
    hi_new = hi_r;
    if (p_lt)      lo_new = sidx_t'(mid_r) + sidx_t'(1);
    else if (p_gt) hi_new = sidx_t'(mid_r) - sidx_t'(1);
  end

  assign sum_new = lo_new + hi_new;
  assign mid_new = POS_W'(sum_new >>> 1);

  assign status.range_empty = lo_r > hi_r;
  assign status.step_done   = p_eq || (lo_new > hi_new);

  assign rd_en   = cmd.issue || (cmd.step && !status.step_done);
  assign rd_addr = cmd.issue ? mid_reg : mid_new;
  assign wr_ok   = cmd.wr_entry && (32'(in_entry_index) < TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_ok) key_table[POS_W'(in_entry_index)] <= in_key_value[KEY_WIDTH-1:0];
    if (rd_en) rd_data_r <= key_table[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_key_value[KEY_WIDTH-1:0];
      ceil_r <= (in_req_type == REQ_CEIL);
      hit_r  <= 1'b0;
      lo_r   <= '0;
      hi_r   <= sidx_t'(n_clamp) - sidx_t'(1);
      n_r    <= sidx_t'(n_clamp);
    end else if (cmd.step) begin
      if (p_eq) hit_r <= 1'b1;
      lo_r <= lo_new;
      hi_r <= hi_new;
    end
    if (rd_en) mid_r <= rd_addr;
  end

  always_comb begin
    if (hit_r) begin
      res_found = 1'b1;
      res_pos   = mid_r;
    end else if (ceil_r) begin
      res_found = lo_r < n_r;
      res_pos   = POS_W'(lo_r);
    end else begin
      res_found = hi_r >= sidx_t'(0);
      res_pos   = POS_W'(hi_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r <= res_found;
      out_pos_r   <= res_found ? IDX_W'(res_pos) : '0;
    end
  end

  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule : stfcs_dp
`default_nettype wire

FILE: rtl/sorted_table_floor_ceiling_search.sv
`default_nettype none
// Write transaction: written to the table as it is accepted; the next one
// can be taken the cycle after. Search: accept, setup, one probe per cycle
// (at most ceil(log2(n+1)) probes, 11 for 1024 entries), result (waits while
// the output register is full); no new transaction is taken until it is done.
// Reset clears the sequencer, the output valid and entries_in_use; the key
// table is not cleared and reads undefined until written.
// ----------------------------------------------------------------------------
// sorted_table_floor_ceiling_search
// Loadable sorted key table with binary floor/ceiling search and an APB
// register for the number of entries in use.
// ----------------------------------------------------------------------------
module sorted_table_floor_ceiling_search (
  input  wire                            clk,
  input  wire                            rst_n,
  stfcs_req_if.sink                      in_req,
  stfcs_rsp_if.source                    out_rsp,
  input  wire                            cfg_psel,
  input  wire                            cfg_penable,
  input  wire                            cfg_pwrite,
  input  wire [stfcs_pkg::APB_AW-1:0]    cfg_paddr,
  input  wire [stfcs_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [stfcs_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import stfcs_pkg::*;

  logic [CFG_W-1:0] entries_r;
  ctl_cmd_t         cmd;
  dp_status_t       status;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_ENTRIES) begin
      entries_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == ADDR_ENTRIES) ? APB_DW'(entries_r) : '0;

  stfcs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_req.ready),
    .in_req_type (in_req.req_type),
    .out_valid   (out_rsp.valid),
    .out_ready   (out_rsp.ready),
    .status      (status),
    .cmd         (cmd)
  );

  stfcs_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .in_req_type    (in_req.req_type),
    .in_entry_index (in_req.entry_index),
    .in_key_value   (in_req.key_value),
    .entries_in_use (entries_r),
    .status         (status),
    .out_found      (out_rsp.found),
    .out_position   (out_rsp.position)
  );

endmodule : sorted_table_floor_ceiling_search
`default_nettype wire

FILE: dv/sorted_table_floor_ceiling_search_test.sv
// ----------------------------------------------------------------------------
// sorted_table_floor_ceiling_search_test
// Loads sorted (and some unsorted) key tables through write transactions,
// sets the entry count over APB and checks every floor/ceiling search result
// against scripted values or a binary-search predictor kept alongside the block.
// ----------------------------------------------------------------------------
module sorted_table_floor_ceiling_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stfcs_pkg::*;

  localparam logic [REQ_W-1:0]  REQ_UNUSED    = 2'd3;
  localparam logic [FKEY_W-1:0] KEY_MAX       = '1;
  localparam int                SETTLE_CYCLES = 20;
  localparam int                HOLD_CYCLES   = 300;
  localparam int                QUIET_LIMIT   = 3000;
  localparam int                SCRIPT_LEN    = 25;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [IDX_W-1:0]  entry_index;
    logic [FKEY_W-1:0] key_value;
  } search_req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } search_result_t;

  // set_count rows carry the register value in key_value
  typedef struct packed {
    logic              set_count;
    logic [REQ_W-1:0]  req_type;
    logic [IDX_W-1:0]  entry_index;
    logic [FKEY_W-1:0] key_value;
    logic              typed;
    logic              want_found;
    logic [IDX_W-1:0]  want_pos;
  } script_row_t;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b0, REQ_FLOOR,  10'd0,     64'd0,      1'b1, 1'b0, 10'd0}, // empty table
    '{1'b0, REQ_CEIL,   10'd0,     KEY_MAX,    1'b1, 1'b0, 10'd0},
    '{1'b0, REQ_UNUSED, 10'h3FF,   KEY_MAX,    1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_WRITE,  10'd0,     64'd0,      1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_WRITE,  10'd1,     64'd100,    1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_WRITE,  10'd2,     64'd200,    1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_WRITE,  10'd3,     KEY_MAX,    1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_WRITE,  10'h3FF,   64'h5555_AAAA_5555_AAAA, 1'b0, 1'b0, 10'd0},
    '{1'b1, REQ_WRITE,  10'd0,     64'd4,      1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_FLOOR,  10'd0,     64'd0,      1'b1, 1'b1, 10'd0},
    '{1'b0, REQ_CEIL,   10'd0,     KEY_MAX,    1'b1, 1'b1, 10'd3},
    '{1'b0, REQ_FLOOR,  10'd0,     64'd150,    1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_CEIL,   10'd0,     64'd150,    1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_CEIL,   10'd0,     64'd201,    1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_FLOOR,  10'd0,     KEY_MAX - 64'd1, 1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_CEIL,   10'd0,     64'd0,      1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_FLOOR,  10'd0,     64'd99,     1'b0, 1'b0, 10'd0},
    '{1'b1, REQ_WRITE,  10'd0,     64'd1,      1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_CEIL,   10'd0,     64'd1,      1'b1, 1'b0, 10'd0}, // past the only entry
    '{1'b0, REQ_FLOOR,  10'd0,     KEY_MAX,    1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_WRITE,  10'd0,     64'd300,    1'b0, 1'b0, 10'd0}, // table now unsorted
    '{1'b1, REQ_WRITE,  10'd0,     64'd4,      1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_FLOOR,  10'd0,     64'd250,    1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_CEIL,   10'd0,     64'd250,    1'b0, 1'b0, 10'd0},
    '{1'b0, REQ_UNUSED, 10'h2AA,   64'd0,      1'b0, 1'b0, 10'd0}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  stfcs_req_if req_ch ();
  stfcs_rsp_if rsp_ch ();

  sorted_table_floor_ceiling_search dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_ch),
    .out_rsp     (rsp_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [FKEY_W-1:0] key_mirror [TABLE_DEPTH];
  logic [CFG_W-1:0]  entry_count;
  logic [FKEY_W-1:0] staged [TABLE_DEPTH];
  search_result_t    pending_lookups [$];

  int errors       = 0;
  int quiet_cycles = 0;
  bit steady       = 1'b0;
  bit hold_off_req = 1'b0;

  function automatic logic [FKEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic int covered_entries();
    return (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
  endfunction

  function automatic search_result_t lookup_floor_ceiling(input logic [FKEY_W-1:0] key,
                                                          input bit ceiling);
    search_result_t res;
    int n, lo, hi, mid;
    res = '0;
    n   = covered_entries();
    lo  = 0;
    hi  = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key_mirror[mid] < key) begin
        lo = mid + 1;
      end else if (key_mirror[mid] > key) begin
        hi = mid - 1;
      end else begin
        res.found    = 1'b1;
        res.position = IDX_W'(mid);
        return res;
      end
    end
    if (ceiling && lo < n) begin
      res.found    = 1'b1;
      res.position = IDX_W'(lo);
    end else if (!ceiling && hi >= 0) begin
      res.found    = 1'b1;
      res.position = IDX_W'(hi);
    end
    return res;
  endfunction

  // style 0: sorted, wide spread; 1: sorted, mostly duplicates;
  // 2: sorted, last entry at the top of the key range; 3: unsorted
  function automatic void stage_keys(input int n, input int style);
    int s;
    logic [FKEY_W-1:0] acc, lift;
    s   = (style == 1) ? $urandom_range(2) : $urandom_range(62 - $clog2(n + 2));
    acc = rand_key() >> (64 - s);
    for (int i = 0; i < n; i++) begin
      if (style == 3) begin
        staged[i] = rand_key();
      end else begin
        staged[i] = acc;
        acc += rand_key() >> (64 - s);
      end
    end
    if (style == 2) begin
      lift = KEY_MAX - staged[n-1];
      for (int i = 0; i < n; i++) staged[i] += lift;
    end
  endfunction

  function automatic search_req_t random_probe(input bit searches_only);
    search_req_t r;
    int pick, n, j;
    n             = covered_entries();
    r.entry_index = IDX_W'($urandom);
    r.key_value   = rand_key();
    pick          = searches_only ? $urandom_range(10, 99) : $urandom_range(99);
    if (pick < 5) begin
      r.req_type = REQ_UNUSED;
    end else if (pick < 10) begin
      // write outside the searched range, or rewrite an entry unchanged
      r.req_type = REQ_WRITE;
      if (n < TABLE_DEPTH) r.entry_index = IDX_W'(n + $urandom_range(TABLE_DEPTH - 1 - n));
      else r.key_value = key_mirror[r.entry_index];
    end else begin
      r.req_type = (pick < 55) ? REQ_FLOOR : REQ_CEIL;
      j = $urandom_range(9);
      if (n > 0 && j < 7) r.key_value = key_mirror[$urandom_range(n - 1)] + 64'(j % 3) - 64'd1;
      else if (j == 7) r.key_value = '0;
      else if (j == 8) r.key_value = KEY_MAX;
    end
    return r;
  endfunction

  task automatic offer(input search_req_t r, input bit typed = 1'b0,
                       input search_result_t want = '0);
    while (!steady && $urandom_range(99) < 19) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.req_type;
    req_ch.entry_index <= r.entry_index;
    req_ch.key_value   <= r.key_value;
    do @(posedge clk); while (!req_ch.ready);
    case (r.req_type)
      REQ_WRITE: key_mirror[r.entry_index] = r.key_value;
      REQ_FLOOR, REQ_CEIL: begin
        if (typed) pending_lookups.push_back(want);
        else pending_lookups.push_back(lookup_floor_ceiling(r.key_value, r.req_type == REQ_CEIL));
      end
      default: ;
    endcase
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic set_count(input logic [APB_DW-1:0] value);
    settle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_ENTRIES;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    entry_count = value[CFG_W-1:0];
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== APB_DW'(entry_count)) begin
      $error("entries_in_use: expected %0d, actual %0d", entry_count, cfg_prdata);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_lookups.size() == 0) begin
        $error("result with no search outstanding: found %0b, position %0d",
               rsp_ch.found, rsp_ch.position);
        errors++;
      end else begin
        want = pending_lookups.pop_front();
        if (rsp_ch.found !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, rsp_ch.found);
          errors++;
        end
        if (rsp_ch.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, rsp_ch.position);
          errors++;
        end
      end
    end
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sorted_table_floor_ceiling_search test failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= 19);
      end
    end
  end

  initial begin
    search_req_t    r;
    search_result_t want;
    int             n;
    bit             down;

    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_WRITE;
    req_ch.entry_index <= '0;
    req_ch.key_value   <= '0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= ADDR_ENTRIES;
    cfg_pwdata         <= '0;
    entry_count = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].set_count) begin
        set_count(SCRIPT[i].key_value[APB_DW-1:0]);
      end else begin
        r.req_type    = SCRIPT[i].req_type;
        r.entry_index = SCRIPT[i].entry_index;
        r.key_value   = SCRIPT[i].key_value;
        want.found    = SCRIPT[i].want_found;
        want.position = SCRIPT[i].want_pos;
        offer(r, SCRIPT[i].typed, want);
      end
    end

    // small tables, one per key style; searches during a load use the old count
    for (int p = 0; p < 4; p++) begin
      n = $urandom_range(1, 12);
      stage_keys(n, p);
      down = $urandom_range(1);
      for (int i = 0; i < n; i++) begin
        r.req_type    = REQ_WRITE;
        r.entry_index = IDX_W'(down ? n - 1 - i : i);
        r.key_value   = staged[r.entry_index];
        offer(r);
        if ($urandom_range(4) == 0) offer(random_probe(1'b1));
      end
      set_count(APB_DW'(n));
      repeat (8) offer(random_probe(1'b0));
    end

    // full-depth table, first part back to back with no stalls
    stage_keys(TABLE_DEPTH, $urandom_range(1) ? 2 : 0);
    steady = 1'b1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 400) steady = 1'b0;
      r.req_type    = REQ_WRITE;
      r.entry_index = IDX_W'(i);
      r.key_value   = staged[i];
      offer(r);
      if (i % 128 == 127) offer(random_probe(1'b1));
    end

    set_count(APB_DW'(TABLE_DEPTH));
    hold_off_req = 1'b1;
    repeat (24) offer(random_probe(1'b0));

    // count above depth, junk in the unused upper data bits
    set_count({21'($urandom), 11'h7FF});
    repeat (8) offer(random_probe(1'b0));

    // scatter a few unsorted entries through the table
    repeat (8) begin
      r.req_type    = REQ_WRITE;
      r.entry_index = IDX_W'($urandom);
      r.key_value   = rand_key();
      offer(r);
    end
    set_count(APB_DW'(TABLE_DEPTH - 1));
    repeat (8) offer(random_probe(1'b0));

    set_count('0);
    repeat (4) offer(random_probe(1'b0));

    settle();
    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("sorted_table_floor_ceiling_search test passed");
    end else begin
      $display("sorted_table_floor_ceiling_search test failed");
    end
    $finish;
  end

endmodule : sorted_table_floor_ceiling_search_test
